// ===== design/ordered_list_delete_by_value_assert.svh =====
// assertion macros for the ordered list block
`ifndef ORDERED_LIST_DELETE_BY_VALUE_ASSERT_SVH
`define ORDERED_LIST_DELETE_BY_VALUE_ASSERT_SVH

// same-cycle implication, sampled on i_clk, off during reset
`define OLVD_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("olvd check failed");

// next-cycle implication, sampled on i_clk, off during reset
`define OLVD_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("olvd check failed");

`endif

// ===== design/olvd_pkg.sv =====
// types and codes shared by the ordered list block
`default_nettype none

package olvd_pkg;

    localparam logic [1:0] KIND_APPEND = 2'd0;
    localparam logic [1:0] KIND_DELETE = 2'd1;
    localparam logic [1:0] KIND_DUMP   = 2'd2;

    typedef enum logic [1:0] {
        OP_APPEND = 2'd0,
        OP_DELETE = 2'd1,
        OP_DUMP   = 2'd2
    } t_op;

    typedef enum logic [2:0] {
        ST_APPENDED  = 3'd0,
        ST_FULL      = 3'd1,
        ST_DELETED   = 3'd2,
        ST_NOT_FOUND = 3'd3,
        ST_ENTRY     = 3'd4,
        ST_EMPTY     = 3'd5
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE  = 2'd0,
        S_SCAN  = 2'd1,
        S_SHIFT = 2'd2,
        S_DUMP  = 2'd3
    } t_state;

    typedef struct packed {
        t_op         op;
        logic [31:0] value;
    } t_cmd;

endpackage

`default_nettype wire

// ===== design/ordered_list_delete_by_value.sv =====
// ordered list with append, delete by value and dump
//
//  channel | direction | handshake                 | payload
//  in      | input     | i_in_valid / o_in_stall   | i_kind, i_value
//  out     | output    | o_out_valid / i_out_stall | o_status, o_entry_value,
//          |           |                           | o_entry_count, o_last
//
// append registers its result as the sequencer takes it from the queue; dump
// reads the list memory and registers each entry, one beat a cycle while the
// output is not stalled; delete scans, reading up to the match, then shifts
// the rest down, one pass with at most one list memory read and write a cycle.
// reset is synchronous and clears the count and all control, not the contents.
// an output stall holds the sequencer at its next result; the queue fills up.
`default_nettype none

`include "ordered_list_delete_by_value_assert.svh"

module ordered_list_delete_by_value #(
    parameter int DEPTH = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic [1:0]          i_kind,
    input  logic signed [31:0]  i_value,
    output logic                o_in_stall,
    output logic                o_out_valid,
    output logic [2:0]          o_status,
    output logic signed [31:0]  o_entry_value,
    output logic [4:0]          o_entry_count,
    output logic                o_last,
    input  logic                i_out_stall
);
    import olvd_pkg::*;

    logic w_cmd_valid;
    t_cmd w_cmd;
    logic w_cmd_pop;

    olvd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_kind      (i_kind),
        .i_value     (i_value),
        .o_in_stall  (o_in_stall),
        .o_cmd_valid (w_cmd_valid),
        .o_cmd       (w_cmd),
        .i_cmd_pop   (w_cmd_pop)
    );

    olvd_back #(
        .DEPTH (DEPTH)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd_valid   (w_cmd_valid),
        .i_cmd         (w_cmd),
        .o_cmd_pop     (w_cmd_pop),
        .o_out_valid   (o_out_valid),
        .o_status      (o_status),
        .o_entry_value (o_entry_value),
        .o_entry_count (o_entry_count),
        .o_last        (o_last),
        .i_out_stall   (i_out_stall)
    );

    // only a dump spreads over several beats
    `OLVD_ASSERT_NOW(a_multi_is_dump, o_out_valid && !o_last, o_status == ST_ENTRY)
    // value is zero on everything but a dump entry
    `OLVD_ASSERT_NOW(a_value_zero, o_out_valid && (o_status != ST_ENTRY), o_entry_value == 32'sd0)
    // an empty dump reports no entries
    `OLVD_ASSERT_NOW(a_empty_count, o_out_valid && (o_status == ST_EMPTY), o_entry_count == 5'd0)
    // a dump streams without gaps once a beat is taken
    `OLVD_ASSERT_NEXT(a_dump_stream, o_out_valid && !i_out_stall && !o_last, o_out_valid && (o_status == ST_ENTRY))

endmodule

`default_nettype wire

// ===== design/olvd_front.sv =====
// front end: takes input beats, decodes the operation, queues commands
`default_nettype none

module olvd_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic [1:0]          i_kind,
    input  logic signed [31:0]  i_value,
    output logic                o_in_stall,
    output logic                o_cmd_valid,
    output olvd_pkg::t_cmd      o_cmd,
    input  logic                i_cmd_pop
);
    import olvd_pkg::*;

    t_cmd       r_q [2];
    logic       r_wptr, n_wptr;
    logic       r_rptr, n_rptr;
    logic [1:0] r_cnt, n_cnt;
    logic       w_accept;
    logic       w_push;
    logic       w_pop;
    t_cmd       w_cmd;

    assign o_in_stall  = (r_cnt == 2'd2);
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rptr];
    assign w_accept    = i_in_valid && !o_in_stall;
    assign w_pop       = i_cmd_pop && o_cmd_valid;

    // unused kind is dropped here and never reaches the back end
    always_comb begin
        w_cmd.value = i_value;
        w_cmd.op    = OP_APPEND;
        w_push      = 1'b0;
        unique case (i_kind)
            KIND_APPEND: begin
                w_cmd.op = OP_APPEND;
                w_push   = w_accept;
            end
            KIND_DELETE: begin
                w_cmd.op = OP_DELETE;
                w_push   = w_accept;
            end
            KIND_DUMP: begin
                w_cmd.op = OP_DUMP;
                w_push   = w_accept;
            end
            default: begin
                w_push = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_wptr = w_push ? ~r_wptr : r_wptr;
        n_rptr = w_pop ? ~r_rptr : r_rptr;
        n_cnt  = r_cnt + {1'b0, w_push} - {1'b0, w_pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= 1'b0;
            r_rptr <= 1'b0;
            r_cnt  <= 2'd0;
        end else begin
            r_wptr <= n_wptr;
            r_rptr <= n_rptr;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wptr] <= w_cmd;
        end
    end

endmodule

`default_nettype wire

// ===== design/olvd_back.sv =====
// back end: list memory, operation sequencer and output register
`default_nettype none

module olvd_back #(
    parameter int DEPTH = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cmd_valid,
    input  olvd_pkg::t_cmd      i_cmd,
    output logic                o_cmd_pop,
    output logic                o_out_valid,
    output logic [2:0]          o_status,
    output logic signed [31:0]  o_entry_value,
    output logic [4:0]          o_entry_count,
    output logic                o_last,
    input  logic                i_out_stall
);
    import olvd_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [31:0]   r_mem [DEPTH];
    logic [31:0]   r_rd_data;

    t_state        r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_ptr, n_ptr;
    logic          r_chk_vld, n_chk_vld;
    logic [AW-1:0] r_chk_addr, n_chk_addr;
    logic [31:0]   r_val, n_val;

    logic          r_o_vld;
    t_status       r_o_status;
    logic [31:0]   r_o_value;
    logic [4:0]    r_o_count;
    logic          r_o_last;

    logic          w_we;
    logic [AW-1:0] w_wa;
    logic [31:0]   w_wd;
    logic          w_rd_en;
    logic [AW-1:0] w_ra;
    logic          w_can_rd;
    logic          w_o_free;
    logic          w_emit;
    t_status       w_e_status;
    logic [31:0]   w_e_value;
    logic [CW-1:0] w_e_count;
    logic          w_e_last;
    logic [CW+4:0] w_cnt_ext;
    logic          w_dump_last;

    assign w_o_free    = !r_o_vld || !i_out_stall;
    assign w_can_rd    = (r_ptr < r_count);
    assign w_dump_last = ((CW'(r_chk_addr) + CW'(1)) == r_count);
    assign w_cnt_ext   = {5'b0, w_e_count};

    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_ptr      = r_ptr;
        n_chk_vld  = r_chk_vld;
        n_chk_addr = r_chk_addr;
        n_val      = r_val;
        w_we       = 1'b0;
        w_wa       = '0;
        w_wd       = '0;
        w_rd_en    = 1'b0;
        w_ra       = r_ptr[AW-1:0];
        o_cmd_pop  = 1'b0;
        w_emit     = 1'b0;
        w_e_status = ST_APPENDED;
        w_e_value  = '0;
        w_e_count  = r_count;
        w_e_last   = 1'b1;

        unique case (r_state)
            S_IDLE: begin
                if (i_cmd_valid && w_o_free) begin
                    o_cmd_pop = 1'b1;
                    n_val     = i_cmd.value;
                    n_ptr     = '0;
                    n_chk_vld = 1'b0;
                    unique case (i_cmd.op)
                        OP_APPEND: begin
                            w_emit = 1'b1;
                            if (r_count == CW'(DEPTH)) begin
                                w_e_status = ST_FULL;
                            end else begin
                                w_we       = 1'b1;
                                w_wa       = r_count[AW-1:0];
                                w_wd       = i_cmd.value;
                                n_count    = r_count + CW'(1);
                                w_e_count  = r_count + CW'(1);
                                w_e_status = ST_APPENDED;
                            end
                        end
                        OP_DELETE: begin
                            n_state = S_SCAN;
                        end
                        OP_DUMP: begin
                            if (r_count == '0) begin
                                w_emit     = 1'b1;
                                w_e_status = ST_EMPTY;
                            end else begin
                                n_state = S_DUMP;
                            end
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                // r_rd_data holds the entry at r_chk_addr, read issued last cycle
                priority if (r_chk_vld && (r_rd_data == r_val)) begin
                    n_state    = S_SHIFT;
                    w_rd_en    = w_can_rd;
                    n_chk_vld  = w_can_rd;
                    n_chk_addr = r_ptr[AW-1:0];
                    if (w_can_rd) begin
                        n_ptr = r_ptr + CW'(1);
                    end
                end else if (!r_chk_vld && (r_ptr == r_count)) begin
                    if (w_o_free) begin
                        w_emit     = 1'b1;
                        w_e_status = ST_NOT_FOUND;
                        n_state    = S_IDLE;
                    end
                end else begin
                    w_rd_en    = w_can_rd;
                    n_chk_vld  = w_can_rd;
                    n_chk_addr = r_ptr[AW-1:0];
                    if (w_can_rd) begin
                        n_ptr = r_ptr + CW'(1);
                    end
                end
            end
            S_SHIFT: begin
                // move each later entry down one place while the next is read
                if (r_chk_vld) begin
                    w_we       = 1'b1;
                    w_wa       = r_chk_addr - AW'(1);
                    w_wd       = r_rd_data;
                    w_rd_en    = w_can_rd;
                    n_chk_vld  = w_can_rd;
                    n_chk_addr = r_ptr[AW-1:0];
                    if (w_can_rd) begin
                        n_ptr = r_ptr + CW'(1);
                    end
                end else if (w_o_free) begin
                    w_emit     = 1'b1;
                    w_e_status = ST_DELETED;
                    w_e_count  = r_count - CW'(1);
                    n_count    = r_count - CW'(1);
                    n_state    = S_IDLE;
                end
            end
            S_DUMP: begin
                if (!r_chk_vld || w_o_free) begin
                    if (r_chk_vld) begin
                        w_emit     = 1'b1;
                        w_e_status = ST_ENTRY;
                        w_e_value  = r_rd_data;
                        w_e_last   = w_dump_last;
                        if (w_dump_last) begin
                            n_state = S_IDLE;
                        end
                    end
                    w_rd_en    = w_can_rd;
                    n_chk_vld  = w_can_rd;
                    n_chk_addr = r_ptr[AW-1:0];
                    if (w_can_rd) begin
                        n_ptr = r_ptr + CW'(1);
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_ptr     <= '0;
            r_chk_vld <= 1'b0;
            r_o_vld   <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_ptr     <= n_ptr;
            r_chk_vld <= n_chk_vld;
            r_o_vld   <= w_emit || (r_o_vld && i_out_stall);
        end
    end

    always_ff @(posedge i_clk) begin
        r_chk_addr <= n_chk_addr;
        r_val      <= n_val;
        if (w_emit) begin
            r_o_status <= w_e_status;
            r_o_value  <= w_e_value;
            r_o_count  <= w_cnt_ext[4:0];
            r_o_last   <= w_e_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_wa] <= w_wd;
        end
        if (w_rd_en) begin
            r_rd_data <= r_mem[w_ra];
        end
    end

    assign o_out_valid   = r_o_vld;
    assign o_status      = r_o_status;
    assign o_entry_value = r_o_value;
    assign o_entry_count = r_o_count;
    assign o_last        = r_o_last;

endmodule

`default_nettype wire
